>>> rtl/rs15_pkg.sv
// shared types, constants and GF(16) helpers for the rs15 syndrome decoder
// no dependencies
`timescale 1ns / 1ps
package rs15_pkg;
  localparam int CORRECTABLE = 2;
  localparam int CODE_LENGTH = 15;
  localparam int SYN_DEPTH = 5;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  typedef enum logic [1:0] {
    OP_LOAD_SYN = 2'd0,
    OP_LOAD_RCV = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_FIXED = 2'd1,
    ST_FAIL = 2'd2
  } lane_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BM,
    S_CHIEN,
    S_FORNEY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic bm_init;
    logic bm_step;
    logic chien_step;
    logic forney;
    logic emit;
    logic [3:0] cnt;
  } cmd_t;

  function automatic logic [3:0] gf_exp(input logic [3:0] e);
    logic [3:0] t [0:15];
    t = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
          4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9, 4'd0};
    return t[e];
  endfunction

  function automatic logic [3:0] gf_log(input logic [3:0] a);
    logic [3:0] t [0:15];
    t = '{4'd0, 4'd0, 4'd1, 4'd4, 4'd2, 4'd8, 4'd5, 4'd10,
          4'd3, 4'd14, 4'd9, 4'd7, 4'd6, 4'd13, 4'd11, 4'd12};
    return t[a];
  endfunction

  // sum of two exponents reduced fully into 0..14
  function automatic logic [3:0] mod15_add(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd15) s = s - 5'd15;
    if (s >= 5'd15) s = s - 5'd15;
    return s[3:0];
  endfunction

  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    if (a == 4'd0 || b == 4'd0) return 4'd0;
    return gf_exp(mod15_add(gf_log(a), gf_log(b)));
  endfunction

  function automatic logic [3:0] gf_inv(input logic [3:0] a);
    if (a == 4'd0) return 4'd0;
    return gf_exp(mod15_add(4'd15 - gf_log(a), 4'd0));
  endfunction

  function automatic logic [3:0] gf_pow(input logic [3:0] a);
    return gf_exp(mod15_add(a, 4'd0));
  endfunction
endpackage

>>> rtl/rs15_ctrl.sv
// controller for the rs15 decoder: sequences bm, chien, forney and emit
// depends on rs15_pkg
`timescale 1ns / 1ps
module rs15_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] op,
  output logic busy,
  output rs15_pkg::cmd_t cmd
);
  rs15_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rs15_pkg::S_IDLE;
      cnt <= 4'd0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      rs15_pkg::S_IDLE: begin
        if (start && op == rs15_pkg::OP_DECODE) begin
          state_next = rs15_pkg::S_BM;
          cnt_next = 4'd1;
        end
      end
      rs15_pkg::S_BM: begin
        if (cnt == 4'd4) begin
          state_next = rs15_pkg::S_CHIEN;
          cnt_next = 4'd1;
        end else cnt_next = cnt + 4'd1;
      end
      rs15_pkg::S_CHIEN: begin
        if (cnt == 4'd15) begin
          state_next = rs15_pkg::S_FORNEY;
          cnt_next = 4'd0;
        end else cnt_next = cnt + 4'd1;
      end
      rs15_pkg::S_FORNEY: begin
        state_next = rs15_pkg::S_EMIT;
        cnt_next = 4'd0;
      end
      rs15_pkg::S_EMIT: begin
        if (cnt == 4'(rs15_pkg::CODE_LENGTH - 1)) begin
          state_next = rs15_pkg::S_IDLE;
          cnt_next = 4'd0;
        end else cnt_next = cnt + 4'd1;
      end
      default: state_next = rs15_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != rs15_pkg::S_IDLE);
    cmd = '0;
    cmd.cnt = cnt;
    cmd.bm_init = (state == rs15_pkg::S_IDLE) && start && op == rs15_pkg::OP_DECODE;
    cmd.bm_step = (state == rs15_pkg::S_BM);
    cmd.chien_step = (state == rs15_pkg::S_CHIEN);
    cmd.forney = (state == rs15_pkg::S_FORNEY);
    cmd.emit = (state == rs15_pkg::S_EMIT);
  end
endmodule

>>> rtl/rs15_lane.sv
// one GF(16) nibble lane: berlekamp-massey, chien search and forney correction
// depends on rs15_pkg
`timescale 1ns / 1ps
module rs15_lane (
  input  logic clk,
  input  rs15_pkg::cmd_t cmd,
  input  logic [3:0] syn [0:4],
  input  logic [3:0] rcv_nib,
  output logic [3:0] out_nib,
  output logic [1:0] status
);
  // locator kept at 8 coefficients past the constant, as the bm updates allow
  localparam int PL = 9;
  logic [3:0] lam [0:PL-1];
  logic [3:0] bpol [0:PL-1];
  logic [3:0] bdisc;
  logic [3:0] deg;
  logic [3:0] shift;
  logic any_syn;
  // chien results: up to two roots recorded
  logic [3:0] root0, root1;
  logic [3:0] cnt_roots;
  logic [3:0] evals0, evals1;
  logic [3:0] mag0, mag1;
  logic ok;

  logic [3:0] d;
  logic [3:0] coef;
  logic [3:0] r;
  always_comb begin
    r = cmd.cnt;
    d = syn[r[2:0]];
    for (int i = 1; i < 4; i++)
      if (4'(i) <= deg && 4'(i) < r)
        d = d ^ rs15_pkg::gf_mul(lam[i], syn[3'(r - 4'(i))]);
    coef = rs15_pkg::gf_mul(d, rs15_pkg::gf_inv(bdisc));
  end

  // chien evaluation of lambda at alpha^cnt for degree <= 2 (others fail anyway)
  logic [3:0] cv;
  logic [3:0] e2;
  always_comb begin
    e2 = rs15_pkg::mod15_add(rs15_pkg::mod15_add(cmd.cnt, 4'd0), rs15_pkg::mod15_add(cmd.cnt, 4'd0));
    cv = lam[0] ^ rs15_pkg::gf_mul(lam[1], rs15_pkg::gf_pow(cmd.cnt));
    if (rs15_pkg::CORRECTABLE >= 2)
      cv = cv ^ rs15_pkg::gf_mul(lam[2], rs15_pkg::gf_exp(e2));
  end

  always_ff @(posedge clk) begin
    if (cmd.bm_init) begin
      for (int i = 0; i < PL; i++) begin
        lam[i] <= (i == 0) ? 4'd1 : 4'd0;
        bpol[i] <= (i == 0) ? 4'd1 : 4'd0;
      end
      bdisc <= 4'd1;
      deg <= 4'd0;
      shift <= 4'd1;
      cnt_roots <= 4'd0;
      any_syn <= (syn[0] | syn[1] | syn[2] | syn[3] | syn[4]) != 4'd0;
    end else if (cmd.bm_step) begin
      if (d == 4'd0) shift <= shift + 4'd1;
      else begin
        for (int i = 0; i < PL; i++)
          if (4'(i) >= shift)
            lam[i] <= lam[i] ^ rs15_pkg::gf_mul(coef, bpol[i - int'(shift)]);
        if ({deg, 1'b0} <= {1'b0, r - 4'd1}) begin
          deg <= r - deg;
          for (int i = 0; i < PL; i++) bpol[i] <= lam[i];
          bdisc <= d;
          shift <= 4'd1;
        end else shift <= shift + 4'd1;
      end
    end else if (cmd.chien_step) begin
      if (cv == 4'd0) begin
        if (cnt_roots == 4'd0) root0 <= cmd.cnt;
        if (cnt_roots == 4'd1) root1 <= cmd.cnt;
        cnt_roots <= cnt_roots + 4'd1;
      end
    end else if (cmd.forney) begin
      mag0 <= evals0;
      mag1 <= evals1;
      ok <= any_syn && deg <= 4'(rs15_pkg::CORRECTABLE) && deg <= 4'd2 && cnt_roots == deg;
    end
  end

  // forney for degree <= 2; z1 = s1^l1, z2 = s2^l2^l1*s1
  logic [3:0] z1, z2;
  logic [3:0] loc0, loc1;
  always_comb begin
    z1 = syn[1] ^ lam[1];
    z2 = syn[2] ^ lam[2] ^ rs15_pkg::gf_mul(lam[1], syn[1]);
    loc0 = rs15_pkg::mod15_add(4'd15 - root0, 4'd0);
    loc1 = rs15_pkg::mod15_add(4'd15 - root1, 4'd0);
  end

  function automatic logic [3:0] mag(input logic [3:0] z1v, input logic [3:0] z2v,
                                     input logic [3:0] ri, input logic [3:0] lo,
                                     input logic two);
    logic [3:0] num, den, e;
    e = rs15_pkg::mod15_add(ri, ri);
    num = 4'd1 ^ rs15_pkg::gf_mul(z1v, rs15_pkg::gf_pow(ri));
    if (two) num = num ^ rs15_pkg::gf_mul(z2v, rs15_pkg::gf_exp(e));
    den = two ? (4'd1 ^ rs15_pkg::gf_exp(rs15_pkg::mod15_add(lo, ri))) : 4'd1;
    if (num == 4'd0) return 4'd0;
    return rs15_pkg::gf_mul(num, rs15_pkg::gf_inv(den));
  endfunction

  always_comb begin
    evals0 = (deg >= 4'd1) ? mag(z1, z2, root0, loc1, deg == 4'd2) : 4'd0;
    evals1 = (deg == 4'd2) ? mag(z1, z2, root1, loc0, 1'b1) : 4'd0;
  end

  always_comb begin
    out_nib = rcv_nib;
    if (ok) begin
      if (deg >= 4'd1 && cmd.cnt == loc0) out_nib = out_nib ^ mag0;
      if (deg == 4'd2 && cmd.cnt == loc1) out_nib = out_nib ^ mag1;
    end
    if (!any_syn) status = rs15_pkg::ST_CLEAN;
    else if (ok) status = rs15_pkg::ST_FIXED;
    else status = rs15_pkg::ST_FAIL;
  end
endmodule

>>> rtl/rs15_datapath.sv
// datapath: syndrome and received stores, two nibble lanes, output register
// depends on rs15_pkg, rs15_lane
`timescale 1ns / 1ps
module rs15_datapath (
  input  logic clk,
  input  logic rst,
  input  logic load_en,
  input  logic [1:0] op,
  input  logic [3:0] position,
  input  logic [7:0] value,
  input  rs15_pkg::cmd_t cmd,
  output logic strobe,
  output logic [3:0] symbol_index,
  output logic [7:0] corrected_byte,
  output logic [1:0] low_status,
  output logic [1:0] high_status,
  output logic last
);
  logic [7:0] syn_store [0:rs15_pkg::SYN_DEPTH-1];
  logic [7:0] rcv_store [0:rs15_pkg::CODE_LENGTH-1];
  logic [3:0] syn_lo [0:4];
  logic [3:0] syn_hi [0:4];
  logic [3:0] lo_nib, hi_nib;
  logic [1:0] lo_st, hi_st;
  logic [7:0] cur;

  always_ff @(posedge clk) begin
    if (load_en && op == rs15_pkg::OP_LOAD_SYN && position < 4'(rs15_pkg::SYN_DEPTH))
      syn_store[position[2:0]] <= value;
    if (load_en && op == rs15_pkg::OP_LOAD_RCV && position < 4'(rs15_pkg::CODE_LENGTH))
      rcv_store[position] <= value;
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      syn_lo[i] = syn_store[i][3:0] & rs15_pkg::NIBBLE_MASK;
      syn_hi[i] = syn_store[i][7:4];
    end
    cur = rcv_store[cmd.cnt];
  end

  rs15_lane u_lo (
    .clk(clk), .cmd(cmd), .syn(syn_lo), .rcv_nib(cur[3:0]),
    .out_nib(lo_nib), .status(lo_st));
  rs15_lane u_hi (
    .clk(clk), .cmd(cmd), .syn(syn_hi), .rcv_nib(cur[7:4]),
    .out_nib(hi_nib), .status(hi_st));

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.emit;
    symbol_index <= cmd.cnt;
    corrected_byte <= {hi_nib, lo_nib};
    low_status <= lo_st;
    high_status <= hi_st;
    last <= cmd.emit && cmd.cnt == 4'(rs15_pkg::CODE_LENGTH - 1);
  end
endmodule

>>> rtl/rs15_11_syndrome_difference_decoder.sv
// top level of the rs15 syndrome-difference decoder
// depends on rs15_pkg, rs15_ctrl, rs15_datapath
`timescale 1ns / 1ps
// Loads (op 0, op 1) and op 3 produce nothing. A decode (op 2) keeps busy high
// through the berlekamp-massey, chien (one position per cycle), forney and emit
// states; results appear one per cycle with strobe high, registered in the cycle
// after each emit step, with last on the fifteenth. The receiver cannot stall:
// every strobe cycle is a transfer, so it must take one result per cycle.
module rs15_11_syndrome_difference_decoder (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] op,
  input  logic [3:0] position,
  input  logic [7:0] value,
  output logic strobe,
  output logic [3:0] symbol_index,
  output logic [7:0] corrected_byte,
  output logic [1:0] low_status,
  output logic [1:0] high_status,
  output logic last
);
  rs15_pkg::cmd_t cmd;

  // sequencer
  rs15_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .busy(busy), .cmd(cmd));

  // stores, lanes and result register
  rs15_datapath u_dp (
    .clk(clk), .rst(rst), .load_en(start && !busy), .op(op),
    .position(position), .value(value), .cmd(cmd), .strobe(strobe),
    .symbol_index(symbol_index), .corrected_byte(corrected_byte),
    .low_status(low_status), .high_status(high_status), .last(last));
endmodule
